>>> rtl/cems_pkg.sv
// ============================================================================
// cems_pkg
// Shared types, register indexes and saturating arithmetic for the motion step.
// ============================================================================
package cems_pkg;

    localparam int WORD_W   = 32;
    localparam int DT_W     = 31;
    localparam int SCALED_W = 47;
    localparam int SUM_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_ACCEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VSPEED_LIMITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_BOUNDS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BOUNDS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_BOUNDS      = 3'd5;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic signed [SCALED_W-1:0] t_scaled;
    typedef logic [DT_W-1:0]            t_dt;

    typedef struct packed {
        logic       valid;
        logic       phys;
        logic       grav;
        logic [2:0] mask;
        logic       grounded;
    } t_ctrl;

    localparam logic signed [SUM_W-1:0] SAT_HI = 48'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_LO = -48'sd2147483648;

    function automatic t_word add_sat(input t_word a, input t_scaled b);
        logic signed [SUM_W-1:0] s;
        s = {{(SUM_W-WORD_W){a[WORD_W-1]}}, a} + {b[SCALED_W-1], b};
        if (s > SAT_HI) begin
            return SAT_HI[WORD_W-1:0];
        end else if (s < SAT_LO) begin
            return SAT_LO[WORD_W-1:0];
        end
        return s[WORD_W-1:0];
    endfunction

endpackage

>>> rtl/cems_scale.sv
// ============================================================================
// cems_scale
// Multiplies a Q16.16 value by the time step and floors the result back to
// Q16.16 (arithmetic shift of the exact product).
// ============================================================================
module cems_scale (
    input  cems_pkg::t_word   i_value,
    input  cems_pkg::t_dt     i_dt,
    output cems_pkg::t_scaled o_scaled
);

    logic signed [63:0] w_prod;

    assign w_prod   = i_value * $signed({1'b0, i_dt});
    assign o_scaled = w_prod[62:16];

endmodule

>>> rtl/cems_vel.sv
// ============================================================================
// cems_vel
// Velocity half: acceleration and gravity products, gravity update with the
// descent limit, velocity integration and the vertical speed limits.
// ============================================================================
module cems_vel (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  cems_pkg::t_word         i_p [3],
    input  cems_pkg::t_word         i_v [3],
    input  cems_pkg::t_word         i_a [3],
    input  logic [1:0]              i_mode,
    input  logic [2:0]              i_mask,
    input  logic                    i_grounded,
    input  cems_pkg::t_dt           i_dt,
    input  cems_pkg::t_word         i_gravity,
    input  logic [63:0]             i_vlim,
    output cems_pkg::t_ctrl         o_ctrl,
    output cems_pkg::t_word         o_p [3],
    output cems_pkg::t_word         o_v [3]
);

    cems_pkg::t_scaled w_ad [3];
    cems_pkg::t_scaled w_gd;
    cems_pkg::t_word   w_desc;
    cems_pkg::t_word   w_asc;
    cems_pkg::t_ctrl   n_ctrl1;
    logic              w_upd;

    cems_pkg::t_ctrl   r_ctrl1;
    cems_pkg::t_word   r_p1 [3];
    cems_pkg::t_word   r_v1 [3];
    cems_pkg::t_scaled r_ad1 [3];
    cems_pkg::t_scaled r_gd1;

    cems_pkg::t_ctrl   r_ctrl2;
    cems_pkg::t_word   r_p2 [3];
    cems_pkg::t_word   r_v2 [3];
    cems_pkg::t_scaled r_adz2;
    cems_pkg::t_word   n_vz2;
    cems_pkg::t_word   n_vx2;
    cems_pkg::t_word   n_vy2;

    cems_pkg::t_ctrl   r_ctrl3;
    cems_pkg::t_word   r_p3 [3];
    cems_pkg::t_word   r_v3 [3];
    cems_pkg::t_word   n_vz3;

    assign w_desc = i_vlim[31:0];
    assign w_asc  = i_vlim[63:32];

    for (genvar g = 0; g < 3; g++) begin : g_acc
        cems_scale u_scale (
            .i_value  (i_a[g]),
            .i_dt     (i_dt),
            .o_scaled (w_ad[g])
        );
    end

    cems_scale u_grav_scale (
        .i_value  (i_gravity),
        .i_dt     (i_dt),
        .o_scaled (w_gd)
    );

    always_comb begin
        w_upd             = (i_dt != '0);
        n_ctrl1.valid     = i_valid;
        n_ctrl1.phys      = w_upd && (i_mode != 2'd0);
        n_ctrl1.grav      = w_upd && i_mode[1];
        n_ctrl1.mask      = w_upd ? i_mask : 3'b000;
        n_ctrl1.grounded  = (w_upd && (i_mode != 2'd0)) ? 1'b0 : i_grounded;
    end

    always_comb begin
        n_vx2 = cems_pkg::add_sat(r_v1[cems_pkg::AXIS_X], r_ad1[cems_pkg::AXIS_X]);
        n_vy2 = cems_pkg::add_sat(r_v1[cems_pkg::AXIS_Y], r_ad1[cems_pkg::AXIS_Y]);
        n_vz2 = r_v1[cems_pkg::AXIS_Z];
        if (r_ctrl1.grav) begin
            n_vz2 = cems_pkg::add_sat(r_v1[cems_pkg::AXIS_Z], r_gd1);
            if (n_vz2 < w_desc) begin
                n_vz2 = w_desc;
            end
        end
    end

    always_comb begin
        n_vz3 = cems_pkg::add_sat(r_v2[cems_pkg::AXIS_Z], r_adz2);
        if (r_ctrl2.phys) begin
            if (n_vz3 > w_asc) begin
                n_vz3 = w_asc;
            end
            if (n_vz3 < w_desc) begin
                n_vz3 = w_desc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1.valid <= 1'b0;
            r_ctrl2.valid <= 1'b0;
            r_ctrl3.valid <= 1'b0;
        end else begin
            r_ctrl1.valid <= n_ctrl1.valid;
            r_ctrl2.valid <= r_ctrl1.valid;
            r_ctrl3.valid <= r_ctrl2.valid;
        end

        r_ctrl1.phys     <= n_ctrl1.phys;
        r_ctrl1.grav     <= n_ctrl1.grav;
        r_ctrl1.mask     <= n_ctrl1.mask;
        r_ctrl1.grounded <= n_ctrl1.grounded;
        r_p1             <= i_p;
        r_v1             <= i_v;
        r_ad1            <= w_ad;
        r_gd1            <= w_gd;

        r_ctrl2.phys     <= r_ctrl1.phys;
        r_ctrl2.grav     <= r_ctrl1.grav;
        r_ctrl2.mask     <= r_ctrl1.mask;
        r_ctrl2.grounded <= r_ctrl1.grounded;
        r_p2             <= r_p1;
        r_v2[cems_pkg::AXIS_X] <= n_vx2;
        r_v2[cems_pkg::AXIS_Y] <= n_vy2;
        r_v2[cems_pkg::AXIS_Z] <= n_vz2;
        r_adz2           <= r_ad1[cems_pkg::AXIS_Z];

        r_ctrl3.phys     <= r_ctrl2.phys;
        r_ctrl3.grav     <= r_ctrl2.grav;
        r_ctrl3.mask     <= r_ctrl2.mask;
        r_ctrl3.grounded <= r_ctrl2.grounded;
        r_p3             <= r_p2;
        r_v3[cems_pkg::AXIS_X] <= r_v2[cems_pkg::AXIS_X];
        r_v3[cems_pkg::AXIS_Y] <= r_v2[cems_pkg::AXIS_Y];
        r_v3[cems_pkg::AXIS_Z] <= n_vz3;
    end

    assign o_ctrl = r_ctrl3;
    assign o_p    = r_p3;
    assign o_v    = r_v3;

endmodule

>>> rtl/cems_pos.sv
// ============================================================================
// cems_pos
// Position half: velocity products, position integration and per-axis
// bound clamping with the grounded flag.
// ============================================================================
module cems_pos (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cems_pkg::t_ctrl         i_ctrl,
    input  cems_pkg::t_word         i_p [3],
    input  cems_pkg::t_word         i_v [3],
    input  cems_pkg::t_dt           i_dt,
    input  logic [63:0]             i_bounds [3],
    output logic                    o_valid,
    output cems_pkg::t_word         o_p [3],
    output cems_pkg::t_word         o_v [3],
    output logic                    o_grounded
);

    cems_pkg::t_scaled w_vd [3];

    cems_pkg::t_ctrl   r_ctrl4;
    cems_pkg::t_word   r_p4 [3];
    cems_pkg::t_word   r_v4 [3];
    cems_pkg::t_scaled r_vd4 [3];

    cems_pkg::t_ctrl   r_ctrl5;
    cems_pkg::t_word   r_p5 [3];
    cems_pkg::t_word   r_v5 [3];

    logic              r_valid6;
    cems_pkg::t_word   r_p6 [3];
    cems_pkg::t_word   r_v6 [3];
    logic              r_grounded6;

    cems_pkg::t_word   n_p5 [3];
    cems_pkg::t_word   n_p6 [3];
    cems_pkg::t_word   n_v6 [3];
    logic              n_low_hit [3];
    logic              n_grounded6;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        cems_scale u_scale (
            .i_value  (i_v[g]),
            .i_dt     (i_dt),
            .o_scaled (w_vd[g])
        );

        assign n_p5[g] = cems_pkg::add_sat(r_p4[g], r_vd4[g]);

        always_comb begin
            cems_pkg::t_word lo;
            cems_pkg::t_word hi;
            lo           = i_bounds[g][31:0];
            hi           = i_bounds[g][63:32];
            n_p6[g]      = r_p5[g];
            n_v6[g]      = r_v5[g];
            n_low_hit[g] = 1'b0;
            if (r_ctrl5.mask[g]) begin
                if (r_p5[g] > hi) begin
                    n_p6[g] = hi;
                    if (r_v5[g] > 0) begin
                        n_v6[g] = '0;
                    end
                end else if (r_p5[g] < lo) begin
                    n_p6[g]      = lo;
                    n_low_hit[g] = 1'b1;
                    if (r_v5[g] < 0) begin
                        n_v6[g] = '0;
                    end
                end
            end
        end
    end

    assign n_grounded6 = r_ctrl5.grounded
                      || (n_low_hit[cems_pkg::AXIS_Z] && r_ctrl5.phys);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl4.valid <= 1'b0;
            r_ctrl5.valid <= 1'b0;
            r_valid6      <= 1'b0;
        end else begin
            r_ctrl4.valid <= i_ctrl.valid;
            r_ctrl5.valid <= r_ctrl4.valid;
            r_valid6      <= r_ctrl5.valid;
        end

        r_ctrl4.phys     <= i_ctrl.phys;
        r_ctrl4.grav     <= i_ctrl.grav;
        r_ctrl4.mask     <= i_ctrl.mask;
        r_ctrl4.grounded <= i_ctrl.grounded;
        r_p4             <= i_p;
        r_v4             <= i_v;
        r_vd4            <= w_vd;

        r_ctrl5.phys     <= r_ctrl4.phys;
        r_ctrl5.grav     <= r_ctrl4.grav;
        r_ctrl5.mask     <= r_ctrl4.mask;
        r_ctrl5.grounded <= r_ctrl4.grounded;
        r_p5             <= n_p5;
        r_v5             <= r_v4;

        r_p6             <= n_p6;
        r_v6             <= n_v6;
        r_grounded6      <= n_grounded6;
    end

    assign o_valid    = r_valid6;
    assign o_p        = r_p6;
    assign o_v        = r_v6;
    assign o_grounded = r_grounded6;

endmodule

>>> rtl/clamped_euler_motion_step.sv
// ============================================================================
// clamped_euler_motion_step
// Semi-implicit Euler step for one entity in saturating Q16.16 with gravity,
// vertical speed limits and per-axis position bounds.
// ============================================================================
// Six-stage pipeline: one entity may start in every cycle and busy never
// rises. The result of an entity appears on the outputs with o_valid high for
// one cycle, once it leaves the last stage; the receiver cannot hold it off.
// The depth is set by the two halves: velocity takes a multiply stage
// (acceleration and gravity times the time step) and two saturating add and
// limit stages, position takes a multiply stage (velocity times the time
// step), a saturating add stage and a bound clamp stage. Configuration writes
// are always ready; write only while no entity is in flight.
module clamped_euler_motion_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         i_pos_x,
    input  logic signed [31:0]         i_pos_y,
    input  logic signed [31:0]         i_pos_z,
    input  logic signed [31:0]         i_vel_x,
    input  logic signed [31:0]         i_vel_y,
    input  logic signed [31:0]         i_vel_z,
    input  logic signed [31:0]         i_acc_x,
    input  logic signed [31:0]         i_acc_y,
    input  logic signed [31:0]         i_acc_z,
    input  logic [1:0]                 i_physics_mode,
    input  logic [2:0]                 i_clamp_mask,
    input  logic                       i_grounded_in,
    output logic                       o_valid,
    output logic signed [31:0]         o_new_pos_x,
    output logic signed [31:0]         o_new_pos_y,
    output logic signed [31:0]         o_new_pos_z,
    output logic signed [31:0]         o_new_vel_x,
    output logic signed [31:0]         o_new_vel_y,
    output logic signed [31:0]         o_new_vel_z,
    output logic                       o_grounded,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [63:0]                i_cfg_data
);

    cems_pkg::t_dt   r_time_step;
    cems_pkg::t_word r_gravity;
    logic [63:0]     r_vlim;
    logic [63:0]     r_bounds [3];

    cems_pkg::t_word w_in_p [3];
    cems_pkg::t_word w_in_v [3];
    cems_pkg::t_word w_in_a [3];
    cems_pkg::t_ctrl w_ctrl3;
    cems_pkg::t_word w_p3 [3];
    cems_pkg::t_word w_v3 [3];
    cems_pkg::t_word w_out_p [3];
    cems_pkg::t_word w_out_v [3];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= '0;
            r_gravity   <= '0;
            r_vlim      <= '0;
            r_bounds[0] <= '0;
            r_bounds[1] <= '0;
            r_bounds[2] <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cems_pkg::CFG_TIME_STEP: begin
                    r_time_step <= i_cfg_data[30:0];
                end
                cems_pkg::CFG_GRAVITY_ACCEL: begin
                    r_gravity <= i_cfg_data[31:0];
                end
                cems_pkg::CFG_VSPEED_LIMITS: begin
                    r_vlim <= i_cfg_data;
                end
                cems_pkg::CFG_X_BOUNDS: begin
                    r_bounds[cems_pkg::AXIS_X] <= i_cfg_data;
                end
                cems_pkg::CFG_Y_BOUNDS: begin
                    r_bounds[cems_pkg::AXIS_Y] <= i_cfg_data;
                end
                cems_pkg::CFG_Z_BOUNDS: begin
                    r_bounds[cems_pkg::AXIS_Z] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_in_p[cems_pkg::AXIS_X] = i_pos_x;
    assign w_in_p[cems_pkg::AXIS_Y] = i_pos_y;
    assign w_in_p[cems_pkg::AXIS_Z] = i_pos_z;
    assign w_in_v[cems_pkg::AXIS_X] = i_vel_x;
    assign w_in_v[cems_pkg::AXIS_Y] = i_vel_y;
    assign w_in_v[cems_pkg::AXIS_Z] = i_vel_z;
    assign w_in_a[cems_pkg::AXIS_X] = i_acc_x;
    assign w_in_a[cems_pkg::AXIS_Y] = i_acc_y;
    assign w_in_a[cems_pkg::AXIS_Z] = i_acc_z;

    cems_vel u_vel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_p        (w_in_p),
        .i_v        (w_in_v),
        .i_a        (w_in_a),
        .i_mode     (i_physics_mode),
        .i_mask     (i_clamp_mask),
        .i_grounded (i_grounded_in),
        .i_dt       (r_time_step),
        .i_gravity  (r_gravity),
        .i_vlim     (r_vlim),
        .o_ctrl     (w_ctrl3),
        .o_p        (w_p3),
        .o_v        (w_v3)
    );

    cems_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl3),
        .i_p        (w_p3),
        .i_v        (w_v3),
        .i_dt       (r_time_step),
        .i_bounds   (r_bounds),
        .o_valid    (o_valid),
        .o_p        (w_out_p),
        .o_v        (w_out_v),
        .o_grounded (o_grounded)
    );

    assign o_new_pos_x = w_out_p[cems_pkg::AXIS_X];
    assign o_new_pos_y = w_out_p[cems_pkg::AXIS_Y];
    assign o_new_pos_z = w_out_p[cems_pkg::AXIS_Z];
    assign o_new_vel_x = w_out_v[cems_pkg::AXIS_X];
    assign o_new_vel_y = w_out_v[cems_pkg::AXIS_Y];
    assign o_new_vel_z = w_out_v[cems_pkg::AXIS_Z];

endmodule

>>> tb/sv/clamped_euler_motion_step_test.sv
`timescale 1ns / 1ps
// ============================================================================
// clamped_euler_motion_step_test
// Self-checking bench for the saturating Q16.16 Euler motion step. Directed
// beats cover zero time step, every physics mode, gravity, speed limits, the
// axis bounds, inverted limits and saturation. Random phases follow, each
// under a fresh register setting. An in-bench predictor computes every
// expected state and each result strobe is compared against the oldest one.
// ============================================================================
module clamped_euler_motion_step_test;
    import cems_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int PIPE_SETTLE    = 10;
    localparam int STALL_LIMIT    = 2000;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 150;
    localparam int REPORT_MAX     = 10;
    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] acc;
        logic [1:0]       mode;
        logic [2:0]       mask;
        logic             grounded;
    } t_motion_in;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic             grounded;
    } t_motion_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        step_start = 1'b0;
    t_motion_in  drv_item = '0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    logic        busy;
    logic        o_valid;
    logic        o_cfg_ready;
    logic [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic [31:0] new_vel_x, new_vel_y, new_vel_z;
    logic        new_grounded;

    t_dt         reg_dt = '0;
    t_word       reg_gravity = '0;
    logic [63:0] reg_vlimits = '0;
    logic [63:0] reg_bounds [3] = '{default: '0};

    t_motion_out expected_steps [$];
    t_motion_out beat_got, beat_want;
    int          fail_count = 0;
    int          steps_checked = 0;
    int          reg_writes = 0;
    int          reg_settings = 0;
    int          idle_cycles = 0;
    bit          no_gap = 1'b0;

    clamped_euler_motion_step u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (step_start),
        .busy           (busy),
        .i_pos_x        (drv_item.pos[AXIS_X]),
        .i_pos_y        (drv_item.pos[AXIS_Y]),
        .i_pos_z        (drv_item.pos[AXIS_Z]),
        .i_vel_x        (drv_item.vel[AXIS_X]),
        .i_vel_y        (drv_item.vel[AXIS_Y]),
        .i_vel_z        (drv_item.vel[AXIS_Z]),
        .i_acc_x        (drv_item.acc[AXIS_X]),
        .i_acc_y        (drv_item.acc[AXIS_Y]),
        .i_acc_z        (drv_item.acc[AXIS_Z]),
        .i_physics_mode (drv_item.mode),
        .i_clamp_mask   (drv_item.mask),
        .i_grounded_in  (drv_item.grounded),
        .o_valid        (o_valid),
        .o_new_pos_x    (new_pos_x),
        .o_new_pos_y    (new_pos_y),
        .o_new_pos_z    (new_pos_z),
        .o_new_vel_x    (new_vel_x),
        .o_new_vel_y    (new_vel_y),
        .o_new_vel_z    (new_vel_z),
        .o_grounded     (new_grounded),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic longint sat_word(input longint x);
        if (x > WORD_MAX) return WORD_MAX;
        if (x < WORD_MIN) return WORD_MIN;
        return x;
    endfunction

    // floor(x * dt / 2^16)
    function automatic longint scale_dt(input longint x, input longint dt);
        return (x * dt) >>> 16;
    endfunction

    function automatic t_motion_out predict_step(input t_motion_in it);
        t_motion_out r;
        longint      p [3];
        longint      v [3];
        longint      dt, descent, ascent, lo, hi;
        logic        phys, grav, gnd;
        dt  = longint'(reg_dt);
        gnd = it.grounded;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(it.pos[i]));
            v[i] = longint'($signed(it.vel[i]));
        end
        if (dt != 0) begin
            phys    = (it.mode != 2'd0);
            grav    = it.mode[1];
            descent = longint'($signed(reg_vlimits[31:0]));
            ascent  = longint'($signed(reg_vlimits[63:32]));
            if (phys) gnd = 1'b0;
            if (grav) begin
                v[AXIS_Z] = sat_word(v[AXIS_Z] + scale_dt(longint'(reg_gravity), dt));
                if (v[AXIS_Z] < descent) v[AXIS_Z] = descent;
            end
            for (int i = 0; i < 3; i++) begin
                v[i] = sat_word(v[i] + scale_dt(longint'($signed(it.acc[i])), dt));
            end
            if (phys) begin
                if (v[AXIS_Z] > ascent) v[AXIS_Z] = ascent;
                if (v[AXIS_Z] < descent) v[AXIS_Z] = descent;
            end
            for (int i = 0; i < 3; i++) begin
                p[i] = sat_word(p[i] + scale_dt(v[i], dt));
            end
            for (int i = 0; i < 3; i++) begin
                if (it.mask[i]) begin
                    lo = longint'($signed(reg_bounds[i][31:0]));
                    hi = longint'($signed(reg_bounds[i][63:32]));
                    if (p[i] > hi) begin
                        p[i] = hi;
                        if (v[i] > 0) v[i] = 0;
                    end else if (p[i] < lo) begin
                        p[i] = lo;
                        if (v[i] < 0) v[i] = 0;
                        if (i == AXIS_Z && phys) gnd = 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            r.pos[i] = p[i][31:0];
            r.vel[i] = v[i][31:0];
        end
        r.grounded = gnd;
        return r;
    endfunction

    function automatic logic [31:0] q(input int n);
        return 32'(n * 65536);
    endfunction

    function automatic logic [63:0] pair(input logic [31:0] lo, input logic [31:0] hi);
        return {hi, lo};
    endfunction

    function automatic t_motion_in mk_item(
        input logic [31:0] px, py, pz, vx, vy, vz, ax, ay, az,
        input logic [1:0] mode, input logic [2:0] mask, input logic gnd
    );
        t_motion_in it;
        it.pos      = {pz, py, px};
        it.vel      = {vz, vy, vx};
        it.acc      = {az, ay, ax};
        it.mode     = mode;
        it.mask     = mask;
        it.grounded = gnd;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        int          k;
        logic [31:0] m;
        case ($urandom_range(0, 15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom;
            default: begin
                k = $urandom_range(4, 26);
                m = $urandom & ((32'd1 << k) - 32'd1);
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    function automatic t_motion_in rand_item();
        t_motion_in it;
        for (int i = 0; i < 3; i++) begin
            it.pos[i] = rand_word();
            it.vel[i] = rand_word();
            it.acc[i] = ($urandom_range(0, 3) == 0) ? 32'h0 : rand_word();
        end
        it.mode     = 2'($urandom_range(0, 3));
        it.mask     = 3'($urandom_range(0, 7));
        it.grounded = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [63:0] rand_bounds();
        logic [31:0] c, w;
        c = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        w = $urandom_range(0, 32'h00FF_FFFF);
        case ($urandom_range(0, 4))
            0, 1, 2: return pair(c - w, c + w);
            3: return {$urandom, $urandom};
            default: return pair(32'h8000_0000, 32'h7FFF_FFFF);
        endcase
    endfunction

    task automatic send_step(input t_motion_in item);
        @(negedge i_clk);
        while (!no_gap && $urandom_range(0, 99) < 21) begin
            step_start <= 1'b0;
            drv_item   <= rand_item();
            @(negedge i_clk);
        end
        step_start <= 1'b1;
        drv_item   <= item;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        expected_steps.push_back(predict_step(item));
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        step_start <= 1'b0;
        wait (expected_steps.size() == 0);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_TIME_STEP:     reg_dt = data[DT_W-1:0];
            CFG_GRAVITY_ACCEL: reg_gravity = data[31:0];
            CFG_VSPEED_LIMITS: reg_vlimits = data;
            CFG_X_BOUNDS:      reg_bounds[AXIS_X] = data;
            CFG_Y_BOUNDS:      reg_bounds[AXIS_Y] = data;
            CFG_Z_BOUNDS:      reg_bounds[AXIS_Z] = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_regs(
        input t_dt dt, input logic [31:0] g,
        input logic [63:0] vlim, xb, yb, zb
    );
        write_reg(CFG_TIME_STEP, 64'(dt));
        write_reg(CFG_GRAVITY_ACCEL, 64'(g));
        write_reg(CFG_VSPEED_LIMITS, vlim);
        write_reg(CFG_X_BOUNDS, xb);
        write_reg(CFG_Y_BOUNDS, yb);
        write_reg(CFG_Z_BOUNDS, zb);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        reg_settings++;
    endtask

    task automatic test_reset_passthrough();
        send_step(mk_item('1 >> 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 2'd3, 3'd7, 1'b1));
        send_step(mk_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 2'd2, 3'd7, 1'b0));
        send_step(mk_item(q(5), q(-3), q(0), q(1), q(-1), q(2), q(4), q(0), q(-7),
                          2'd1, 3'd5, 1'b1));
    endtask

    task automatic test_motion_modes();
        wait_quiet();
        apply_regs(31'h0001_0000, q(-10), pair(q(-20), q(15)),
                   pair(q(-100), q(100)), pair(q(-50), q(50)), pair(q(0), q(500)));
        send_step(mk_item(0, 0, q(5), 0, 0, q(-40), 0, 0, 0, 2'd0, 3'd7, 1'b1));
        send_step(mk_item(0, 0, q(50), 0, 0, q(30), 0, 0, q(2), 2'd1, 3'd0, 1'b1));
        send_step(mk_item(0, 0, q(10), 0, 0, q(-15), 0, 0, 0, 2'd2, 3'd4, 1'b0));
        send_step(mk_item(0, 0, q(10), 0, 0, q(-15), 0, 0, q(3), 2'd3, 3'd4, 1'b0));
        send_step(mk_item(q(95), 0, q(20), q(10), 0, 0, 0, 0, 0, 2'd1, 3'd1, 1'b0));
        send_step(mk_item(0, q(-45), q(20), 0, q(-10), 0, 0, q(-1), 0, 2'd1, 3'd2, 1'b1));
        send_step(mk_item(q(200), q(49), q(20), q(-10), q(5), 0, 0, 0, 0, 2'd1, 3'd3, 1'b0));
        send_step(mk_item(32'h0001_8000, 32'hFFFE_8001, 32'h0000_0001, 32'hFFFF_7FFF,
                          32'h0000_4000, 32'hFFFF_FFFF, 32'h0000_C000, 32'hFFFF_3FFF,
                          32'h0000_0003, 2'd2, 3'd7, 1'b1));
    endtask

    task automatic test_limits_and_saturation();
        wait_quiet();
        apply_regs('1, 32'h8000_0000, pair(32'h8000_0000, 32'h7FFF_FFFF),
                   pair(32'h8000_0000, 32'h7FFF_FFFF), pair(32'h8000_0000, 32'h7FFF_FFFF),
                   pair(32'h8000_0000, 32'h7FFF_FFFF));
        send_step(mk_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 2'd1, 3'd7, 1'b0));
        send_step(mk_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 2'd2, 3'd7, 1'b1));
        send_step(mk_item(0, 0, 0, q(1), 0, q(1), q(-1), 0, q(-1), 2'd2, 3'd4, 1'b0));
        // descent above ascent, minimum above maximum, smallest nonzero step
        wait_quiet();
        apply_regs(31'd1, 32'h7FFF_FFFF, pair(q(5), q(-5)),
                   pair(q(100), q(-100)), pair(q(-1), q(1)), pair(q(100), q(-100)));
        send_step(mk_item(0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0,
                          2'd1, 3'd0, 1'b1));
        send_step(mk_item(0, 0, 0, q(3), 0, 0, 0, 0, 0, 2'd2, 3'd7, 1'b0));
        send_step(mk_item(0, q(2), q(-200), 0, q(-2), q(50), 0, 0, 0, 2'd0, 3'd7, 1'b0));
        send_step(mk_item(q(-200), q(-2), q(-200), q(-3), q(-2), q(-3), 0, 0, 0,
                          2'd1, 3'd7, 1'b1));
    endtask

    task automatic test_random_phases();
        t_dt         dt;
        logic [31:0] g, r;
        logic [63:0] vlim;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: dt = '1;
                1: dt = 31'd1;
                default: begin
                    case ($urandom_range(0, 3))
                        0: dt = 31'($urandom_range(1, 255));
                        1: dt = 31'($urandom_range(32'h400, 32'h2_0000));
                        2: dt = 31'($urandom_range(0, 32'h7FFF_FFFF));
                        default: dt = 31'h0001_0000;
                    endcase
                end
            endcase
            case ($urandom_range(0, 3))
                0: g = -$urandom_range(0, 32'h00A0_0000);
                1: g = $urandom;
                2: g = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                default: g = 32'h0;
            endcase
            r = $urandom_range(0, 32'h0100_0000);
            case ($urandom_range(0, 3))
                0: vlim = pair(-r, r);
                1: vlim = {$urandom, $urandom};
                2: vlim = pair(r, -r);
                default: vlim = pair(32'h8000_0000, 32'h7FFF_FFFF);
            endcase
            wait_quiet();
            apply_regs(dt, g, vlim, rand_bounds(), rand_bounds(), rand_bounds());
            no_gap = (ph == 3);
            repeat (RAND_PER_PHASE) send_step(rand_item());
        end
        no_gap = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            beat_got.pos      = {new_pos_z, new_pos_y, new_pos_x};
            beat_got.vel      = {new_vel_z, new_vel_y, new_vel_x};
            beat_got.grounded = new_grounded;
            if (expected_steps.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result beat: pos %h vel %h gnd %b",
                             beat_got.pos, beat_got.vel, beat_got.grounded);
            end else begin
                beat_want = expected_steps.pop_front();
                steps_checked++;
                if (beat_got.pos !== beat_want.pos || beat_got.vel !== beat_want.vel ||
                    beat_got.grounded !== beat_want.grounded) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch on beat %0d", steps_checked);
                        $display("  expected pos z/y/x %h vel z/y/x %h gnd %b",
                                 beat_want.pos, beat_want.vel, beat_want.grounded);
                        $display("  actual   pos z/y/x %h vel z/y/x %h gnd %b",
                                 beat_got.pos, beat_got.vel, beat_got.grounded);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (step_start && busy === 1'b0) || o_valid === 1'b1 ||
            (cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_passthrough();
        test_motion_modes();
        test_limits_and_saturation();
        test_random_phases();
        wait_quiet();
        $display("%0d motion steps checked under %0d register settings (%0d writes)",
                 steps_checked, reg_settings, reg_writes);
        $display("%0d failing beats", fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
